>>> src/abat_pkg.sv
package abat_pkg;

    localparam int BLOCK_W    = 48;
    localparam int SPT_W      = 8;
    localparam int HPC_W      = 5;
    localparam int CAP_W      = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    localparam logic [SPT_W-1:0] SPT_RESET = 8'd63;
    localparam logic [HPC_W-1:0] HPC_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_CHS   = 2'd0,
        MODE_LBA28 = 2'd1,
        MODE_LBA48 = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LBA48_ENABLE = 3'd0,
        REG_LBA28_ENABLE = 3'd1,
        REG_CAPACITY_28  = 3'd2,
        REG_SPT          = 3'd3,
        REG_HPC          = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic             lba48_enable;
        logic             lba28_enable;
        logic [CAP_W-1:0] capacity_28bit;
        logic [SPT_W-1:0] sectors_per_track;
        logic [HPC_W-1:0] heads_per_cylinder;
    } cfg_t;

    // One item as it moves down the chain. work holds the dividend bits
    // still to be consumed at the top and the quotient bits at the bottom.
    typedef struct packed {
        logic               valid;
        mode_t              mode;
        logic [BLOCK_W-1:0] work;
        logic [SPT_W-1:0]   rem_spt;
        logic [HPC_W-1:0]   rem_hpc;
    } cell_t;

endpackage

>>> src/abat_regs.sv
module abat_regs
    import abat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // Decode the write index; drop writes beyond the register list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_LBA48_ENABLE: cfg_next.lba48_enable       = cfg_data[0];
                REG_LBA28_ENABLE: cfg_next.lba28_enable       = cfg_data[0];
                REG_CAPACITY_28:  cfg_next.capacity_28bit     = cfg_data[CAP_W-1:0];
                REG_SPT:          cfg_next.sectors_per_track  = cfg_data[SPT_W-1:0];
                REG_HPC:          cfg_next.heads_per_cylinder = cfg_data[HPC_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lba48_enable       <= 1'b0;
            cfg_reg.lba28_enable       <= 1'b0;
            cfg_reg.capacity_28bit     <= '0;
            cfg_reg.sectors_per_track  <= SPT_RESET;
            cfg_reg.heads_per_cylinder <= HPC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/abat_cell.sv
module abat_cell
    import abat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SPT_W-1:0] spt,
    input  logic [HPC_W-1:0] hpc,
    input  cell_t            cell_in,
    output cell_t            cell_out
);

    cell_t          cell_reg;
    cell_t          cell_next;
    logic [SPT_W:0] part_spt;
    logic [SPT_W:0] diff_spt;
    logic           qbit_spt;
    logic [HPC_W:0] part_hpc;
    logic [HPC_W:0] diff_hpc;
    logic           qbit_hpc;

    // In CHS mode, restoring step by sectors per track, then feed that quotient bit
    // straight into a restoring step by heads per cylinder
    always_comb
    begin
        part_spt = {cell_in.rem_spt, cell_in.work[BLOCK_W-1]};
        diff_spt = part_spt - {1'b0, spt};
        qbit_spt = (part_spt >= {1'b0, spt});
        part_hpc = {cell_in.rem_hpc, qbit_spt};
        diff_hpc = part_hpc - {1'b0, hpc};
        qbit_hpc = (part_hpc >= {1'b0, hpc});

        cell_next       = cell_in;
        if (cell_in.mode == MODE_CHS)
        begin
            cell_next.rem_spt = qbit_spt ? diff_spt[SPT_W-1:0] : part_spt[SPT_W-1:0];
            cell_next.rem_hpc = qbit_hpc ? diff_hpc[HPC_W-1:0] : part_hpc[HPC_W-1:0];
            cell_next.work    = {cell_in.work[BLOCK_W-2:0], qbit_hpc};
        end
        else
        begin
            // Rotate so the block number comes back whole after the last cell
            cell_next.work = {cell_in.work[BLOCK_W-2:0], cell_in.work[BLOCK_W-1]};
        end
    end

    // Clear the cell under reset, then advance every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

>>> src/ata_block_address_translate_core.sv
// ATA block address translation core.
//
// Command channel: present block_number and raise start; the item is taken at
// any rising edge where start is high and busy is low. busy stays low, so a
// new item can be issued in every cycle, one item per cycle sustained.
// Each item runs down a chain of 48 cells, one cell per block number bit;
// each cell does one restoring step by sectors per track and, on the quotient
// bit it just made, one step by heads per cylinder (in CHS mode). An output register
// follows the chain. done is high for exactly one cycle as the item leaves the
// output register, with address_mode, sector_field, cylinder_field,
// head_field, wide_address and address_overflow valid in that cycle. Results
// leave in issue order. The receiver cannot stall; results must be taken when
// done is high.
// Configuration: write registers through cfg_valid/cfg_ready, cfg_index and
// cfg_data (cfg_ready is always high). Index 0 lba48_enable, 1 lba28_enable,
// 2 capacity_28bit, 3 sectors_per_track, 4 heads_per_cylinder; other indexes
// are ignored. Write only while no item is in flight.
// Reset (rst_n low, asynchronous) empties the chain and loads the register
// defaults: LBA off, capacity 0, 63 sectors per track, 16 heads.
module ata_block_address_translate_core
    import abat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [BLOCK_W-1:0]    block_number,
    output logic                  done,
    output logic [1:0]            address_mode,
    output logic [7:0]            sector_field,
    output logic [15:0]           cylinder_field,
    output logic [3:0]            head_field,
    output logic [BLOCK_W-1:0]    wide_address,
    output logic                  address_overflow,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg;
    logic [SPT_W-1:0]   spt_eff;
    logic [HPC_W-1:0]   hpc_eff;
    cell_t              chain [0:BLOCK_W];
    cell_t              tail;
    mode_t              mode_in;

    logic               done_reg;
    logic               done_next;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic [7:0]         sector_reg;
    logic [7:0]         sector_next;
    logic [15:0]        cylinder_reg;
    logic [15:0]        cylinder_next;
    logic [3:0]         head_reg;
    logic [3:0]         head_next;
    logic [BLOCK_W-1:0] wide_reg;
    logic [BLOCK_W-1:0] wide_next;
    logic               overflow_reg;
    logic               overflow_next;

    abat_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign busy = 1'b0;

    // A zero divisor acts as one
    assign spt_eff = (cfg.sectors_per_track == '0) ? SPT_W'(1) : cfg.sectors_per_track;
    assign hpc_eff = (cfg.heads_per_cylinder == '0) ? HPC_W'(1) : cfg.heads_per_cylinder;

    // Pick the addressing mode as the item enters
    always_comb
    begin
        if (cfg.lba48_enable && (block_number > BLOCK_W'(cfg.capacity_28bit)))
        begin
            mode_in = MODE_LBA48;
        end
        else if (cfg.lba28_enable)
        begin
            mode_in = MODE_LBA28;
        end
        else
        begin
            mode_in = MODE_CHS;
        end
    end

    always_comb
    begin
        chain[0].valid   = start && !busy;
        chain[0].mode    = mode_in;
        chain[0].work    = block_number;
        chain[0].rem_spt = '0;
        chain[0].rem_hpc = '0;
    end

    // Advance the item one bit per cell
    for (genvar i = 0; i < BLOCK_W; i++)
    begin : g_cell
        abat_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .spt      (spt_eff),
            .hpc      (hpc_eff),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    assign tail = chain[BLOCK_W];

    // Format the task-file fields from the last cell
    always_comb
    begin
        done_next     = tail.valid;
        mode_next     = tail.mode;
        sector_next   = '0;
        cylinder_next = '0;
        head_next     = '0;
        wide_next     = '0;
        overflow_next = 1'b0;
        case (tail.mode)
            MODE_LBA48:
            begin
                wide_next = tail.work;
            end
            MODE_LBA28:
            begin
                sector_next   = tail.work[7:0];
                cylinder_next = tail.work[23:8];
                head_next     = tail.work[27:24];
                overflow_next = |tail.work[BLOCK_W-1:28];
            end
            MODE_CHS:
            begin
                sector_next   = tail.rem_spt + 8'd1;
                cylinder_next = tail.work[15:0];
                head_next     = tail.rem_hpc[3:0];
                overflow_next = tail.rem_hpc[HPC_W-1] || (|tail.work[BLOCK_W-1:16]);
            end
            default:
            begin
                mode_next = MODE_CHS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        sector_reg   <= sector_next;
        cylinder_reg <= cylinder_next;
        head_reg     <= head_next;
        wide_reg     <= wide_next;
        overflow_reg <= overflow_next;
    end

    assign done             = done_reg;
    assign address_mode     = mode_reg;
    assign sector_field     = sector_reg;
    assign cylinder_field   = cylinder_reg;
    assign head_field       = head_reg;
    assign wide_address     = wide_reg;
    assign address_overflow = overflow_reg;

endmodule
